// ===== hdl/section_filter_deframer_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the section filter deframer.
// The macros expect clk_i and rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef SECTION_FILTER_DEFRAMER_CORE_MACROS_SVH
`define SECTION_FILTER_DEFRAMER_CORE_MACROS_SVH

// Check a property at every rising edge outside reset
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property at every rising edge, reset included
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== hdl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the section filter deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

  // Sizing
  localparam int FILTERS     = 8;
  localparam int MASK_BYTES  = 18;
  localparam int MAX_SECTION = 4096;

  localparam int FI_W   = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int MB_W   = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
  localparam int LEN_W  = 13;
  localparam int MASK_W = 8;
  localparam int ENTRY_W = 24;

  // Stream constants
  localparam logic [7:0]       PAD_BYTE   = 8'hFF;
  localparam logic [LEN_W-1:0] HDR_EXTRA  = 13'd3;
  localparam logic [31:0]      CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0]      CRC_POLY   = 32'h04C1_1DB7;

  // Port widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 1;

  // Item commands
  typedef enum logic [1:0] {
    CMD_STREAM = 2'd0,
    CMD_ENTRY  = 2'd1,
    CMD_FLAGS  = 2'd2
  } cmd_e;

  // Per-filter control flags
  typedef struct packed {
    logic need_diff;
    logic crc_req;
    logic enable;
  } flags_t;

  // Filter table write request
  typedef struct packed {
    logic            entry_we;
    logic            flags_we;
    logic [FI_W-1:0] filter;
    logic [MB_W-1:0] bidx;
    logic [7:0]      value;
    logic [7:0]      care;
    logic [7:0]      differ;
    flags_t          flags;
  } filt_wr_t;

  // Framing result of one section byte
  typedef struct packed {
    logic [7:0]       data;
    logic             is_last;
    logic             crc_ok;
    logic [LEN_W-1:0] sec_len;
    logic             sync_err;
    logic             start;
  } frame_info_t;

endpackage

// ===== hdl/section_filter_deframer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// section_filter_deframer_core
// MPEG PSI section deframer with CRC-32 check and mask/value byte filters.
// ---------------------------------------------------------------------------
// A section byte passes the input register, table read stage and output register.
// Throughput: one item per cycle unless the output stalls; input register, table
// read stage and output register each hold one item and advance independently.
// Reset: asynchronous, clears framing state, CRC, filter flags and entry valid
// bits; filter entries read as zero until written. No clearing pass.
module section_filter_deframer_core
  import sfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // data_byte[7:0], filter_index[10:8], byte_index[15:11], care_mask[23:16],
  // differ_mask[31:24], filter_enable[32], crc_required[33],
  // need_difference[34], zero fill[39:35]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // command[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_byte[7:0], match_mask[15:8], crc_ok[16], total_len[29:17],
  // zero fill[31:30]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // sync_error[0]
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  output logic                 m_axis_tlast
);

  logic                 s0_v_q, s1_v_q, out_v_q;
  logic [S_TDATA_W-1:0] s0_data_q;
  logic [S_TUSER_W-1:0] s0_cmd_q;
  frame_info_t          s1_info_q, fr_info;
  logic                 out_free, s1_adv, s0_fire, s1_fire;
  logic                 fr_emit, rd_in_mask;
  logic [MB_W-1:0]      rd_addr;
  logic [FILTERS-1:0]   match;
  logic [MASK_W-1:0]    mask8;
  filt_wr_t             wr;
  logic [7:0]           out_byte_q, out_mask_q;
  logic                 out_crc_q, out_last_q, out_serr_q;
  logic [LEN_W-1:0]     out_len_q;
  logic [2:0]           fi;
  logic [4:0]           bi;

  // Pipeline flow control
  assign out_free      = !out_v_q || m_axis_tready;
  assign s1_adv        = !s1_v_q || out_free;
  assign s0_fire       = s0_v_q && s1_adv;
  assign s1_fire       = s1_v_q && out_free;
  assign s_axis_tready = !s0_v_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s0_data_q <= s_axis_tdata;
      s0_cmd_q  <= s_axis_tuser;
    end
  end

  // Decode filter table writes
  always_comb begin
    fi             = s0_data_q[10:8];
    bi             = s0_data_q[15:11];
    wr.entry_we    = s0_fire && (s0_cmd_q == CMD_ENTRY) &&
                     (32'(fi) < FILTERS) && (32'(bi) < MASK_BYTES);
    wr.flags_we    = s0_fire && (s0_cmd_q == CMD_FLAGS) && (32'(fi) < FILTERS);
    wr.filter      = FI_W'(fi);
    wr.bidx        = MB_W'(bi);
    wr.value       = s0_data_q[7:0];
    wr.care        = s0_data_q[23:16];
    wr.differ      = s0_data_q[31:24];
    wr.flags.enable    = s0_data_q[32];
    wr.flags.crc_req   = s0_data_q[33];
    wr.flags.need_diff = s0_data_q[34];
  end

  sfd_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s0_fire && (s0_cmd_q == CMD_STREAM)),
    .byte_i       (s0_data_q[7:0]),
    .emit_o       (fr_emit),
    .info_o       (fr_info),
    .rd_addr_o    (rd_addr),
    .rd_in_mask_o (rd_in_mask)
  );

  // Table read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= fr_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_emit) begin
      s1_info_q <= fr_info;
    end
  end

  sfd_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .rd_en_i      (fr_emit),
    .rd_addr_i    (rd_addr),
    .rd_in_mask_i (rd_in_mask),
    .acc_fire_i   (s1_fire),
    .acc_i        (s1_info_q),
    .match_o      (match)
  );

  // Keep the low filters only in the reported mask, and only on the last byte
  always_comb begin
    mask8 = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < FILTERS) begin
        mask8[i] = match[i] && s1_info_q.is_last;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_byte_q <= s1_info_q.data;
      out_mask_q <= mask8;
      out_crc_q  <= s1_info_q.crc_ok;
      out_len_q  <= s1_info_q.sec_len;
      out_last_q <= s1_info_q.is_last;
      out_serr_q <= s1_info_q.sync_err;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_len_q, out_crc_q, out_mask_q, out_byte_q};
  assign m_axis_tuser  = out_serr_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/sfd_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sfd_framer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_framer
// Section framing: padding drop, length decode, position count and CRC-32.
// ---------------------------------------------------------------------------
module sfd_framer
  import sfd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  output logic            emit_o,
  output frame_info_t     info_o,
  output logic [MB_W-1:0] rd_addr_o,
  output logic            rd_in_mask_o
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  phase_e           phase_q, phase_d, phase_eff;
  logic [LEN_W-1:0] pos_q, pos_d, pos, pos_nx;
  logic [LEN_W-1:0] len_q, len_d, len, total;
  logic [3:0]       lhn_q, lhn_d, lhn;
  logic [31:0]      crc_q, crc_d, crc_base, crc_nx;
  logic             start, drop, last, serr, emit;

  // MPEG-2 CRC-32, one byte, MSB first
  function automatic logic [31:0] crc_upd(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Decode one stream byte
  always_comb begin
    start     = (phase_q == PH_HUNT);
    drop      = start && (byte_i == PAD_BYTE);
    emit      = fire_i && !drop;
    phase_eff = start ? PH_HEADER : phase_q;
    pos       = start ? '0 : pos_q;
    len       = start ? '0 : len_q;
    lhn       = start ? '0 : lhn_q;
    crc_base  = start ? CRC_INIT : crc_q;
    crc_nx    = crc_upd(crc_base, byte_i);
    pos_nx    = pos + 1'b1;
    total     = {1'b0, lhn, byte_i} + HDR_EXTRA;

    phase_d = phase_eff;
    lhn_d   = lhn;
    len_d   = len;
    last    = 1'b0;
    serr    = 1'b0;
    if (pos == LEN_W'(1)) begin
      lhn_d = byte_i[3:0];
    end else if (pos == LEN_W'(2)) begin
      len_d = total;
      if (32'(total) > MAX_SECTION) begin
        serr    = 1'b1;
        phase_d = PH_HUNT;
      end else begin
        phase_d = PH_BODY;
        last    = (pos_nx == total);
      end
    end else begin
      last = (phase_eff == PH_BODY) && (pos_nx == len);
    end
    if (last) begin
      phase_d = PH_HUNT;
    end
    pos_d = pos_nx;
    crc_d = crc_nx;
  end

  // Advance framing state on each section byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      len_q   <= '0;
      lhn_q   <= '0;
      crc_q   <= CRC_INIT;
    end else if (emit) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      lhn_q   <= lhn_d;
      crc_q   <= crc_d;
    end
  end

  // Result of this byte and the filter table read address
  always_comb begin
    info_o.data     = byte_i;
    info_o.is_last  = last;
    info_o.crc_ok   = last && (crc_nx == '0);
    info_o.sec_len  = last ? len_d : '0;
    info_o.sync_err = serr;
    info_o.start    = start;
    rd_in_mask_o    = (32'(pos) < MASK_BYTES);
    rd_addr_o       = rd_in_mask_o ? pos[MB_W-1:0] : '0;
  end

  assign emit_o = emit;

endmodule

// ===== hdl/sfd_match.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_match
// Filter table, per-filter compare accumulators and final match mask.
// ---------------------------------------------------------------------------
module sfd_match
  import sfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  filt_wr_t           wr_i,
  input  logic               rd_en_i,
  input  logic [MB_W-1:0]    rd_addr_i,
  input  logic               rd_in_mask_i,
  input  logic               acc_fire_i,
  input  frame_info_t        acc_i,
  output logic [FILTERS-1:0] match_o
);

  logic [ENTRY_W-1:0]    rdata   [FILTERS];
  logic [MASK_BYTES-1:0] vld_q   [FILTERS];
  logic [FILTERS-1:0]    use_q;
  flags_t                flags_q [FILTERS];
  logic [FILTERS-1:0]    pmiss_q, pmiss_d, nseen_q, nseen_d;
  logic [FILTERS-1:0]    hit_miss, hit_seen;

  // One entry RAM per filter, addressed by section byte position
  for (genvar f = 0; f < FILTERS; f++) begin : g_ram
    sfd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MASK_BYTES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_i.entry_we && (wr_i.filter == FI_W'(f))),
      .waddr_i (wr_i.bidx),
      .wdata_i ({wr_i.differ, wr_i.care, wr_i.value}),
      .re_i    (rd_en_i),
      .raddr_i (rd_addr_i),
      .rdata_o (rdata[f])
    );
  end

  // Track written entries; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < FILTERS; f++) begin
        vld_q[f]   <= '0;
        flags_q[f] <= '0;
      end
      use_q <= '0;
    end else begin
      if (wr_i.entry_we) begin
        vld_q[wr_i.filter][wr_i.bidx] <= 1'b1;
      end
      if (wr_i.flags_we) begin
        flags_q[wr_i.filter] <= wr_i.flags;
      end
      if (rd_en_i) begin
        for (int f = 0; f < FILTERS; f++) begin
          use_q[f] <= rd_in_mask_i && vld_q[f][rd_addr_i];
        end
      end
    end
  end

  // Compare the byte against every filter and build the mask
  always_comb begin
    for (int f = 0; f < FILTERS; f++) begin
      hit_miss[f] = use_q[f] && |(rdata[f][15:8]  & (rdata[f][7:0] ^ acc_i.data));
      hit_seen[f] = use_q[f] && |(rdata[f][23:16] & (rdata[f][7:0] ^ acc_i.data));
    end
    pmiss_d = (acc_i.start ? '0 : pmiss_q) | hit_miss;
    nseen_d = (acc_i.start ? '0 : nseen_q) | hit_seen;
    for (int f = 0; f < FILTERS; f++) begin
      match_o[f] = flags_q[f].enable && !pmiss_d[f] &&
                   (!flags_q[f].need_diff || nseen_d[f]) &&
                   (!flags_q[f].crc_req || acc_i.crc_ok);
    end
  end

  // Hold the accumulators across the section
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmiss_q <= '0;
      nseen_q <= '0;
    end else if (acc_fire_i) begin
      pmiss_q <= pmiss_d;
      nseen_q <= nseen_d;
    end
  end

endmodule

// ===== hdl/sfd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the section filter deframer, bound to the top level.
// ---------------------------------------------------------------------------
`include "section_filter_deframer_core_macros.svh"

module sfd_checker
  import sfd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [S_TUSER_W-1:0] s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser,
  input logic                 m_axis_tlast
);

  // No item is offered while reset is applied
  `SFD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid, "item offered in reset")

  // A stalled item holds
  `SFD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled item changed")

  // Report fields stay zero except on the last byte
  `SFD_ASSERT(a_report_zero, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[29:8] == 22'd0, "report set off the last byte")

  // A sync error never closes a section
  `SFD_ASSERT(a_serr_not_last, m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast, "sync error on last byte")

  // A closed section has a legal length
  `SFD_ASSERT(a_len_range, m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[29:17] >= 13'd3) && (32'(m_axis_tdata[29:17]) <= MAX_SECTION), "section length out of range")

endmodule

bind section_filter_deframer_core sfd_checker u_sfd_checker (.*);
